>>> rtl/bcf_pkg.sv
// shared constants for the bracelet canonical form block
package bcf_pkg;

    // fixed field widths of the ports
    localparam int WORD_W = 64;
    localparam int LEN_W  = 7;

    // default and upper limit of the string length
    localparam int MAX_WIDTH_DEF = 64;

    // length register after reset
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

endpackage

>>> rtl/bracelet_canonical_form.sv
// bracelet canonical form: smallest rotation of a word or of its mirror image
//
//   channel | ports                               | dir | beat
//   --------+-------------------------------------+-----+------------------------------
//   input   | s_valid s_ready s_word              | in  | one word to canonicalize
//   result  | m_valid m_ready m_canonical_word    | out | smallest rotation or mirror
//   config  | cfg_wr_en cfg_wr_data               | in  | string length, any edge with en
//
// One word enters per cycle while the pipe is not held; the stages, in order, are
// mask, mirror, doubling, leaf select, then one registered min level per stage of a
// binary compare tree over all MAX_WIDTH rotation pairs.
// All stages move together; when the result register holds a beat that is not
// taken, the whole pipe holds and s_ready drops, so nothing is lost or repeated.
// Synchronous active-low reset clears the valid bits and sets the length to 64.
module bracelet_canonical_form #(
    parameter int MAX_WIDTH = bcf_pkg::MAX_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [bcf_pkg::LEN_W-1:0]   cfg_wr_data,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bcf_pkg::WORD_W-1:0]  s_word,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bcf_pkg::WORD_W-1:0]  m_canonical_word
);
    import bcf_pkg::*;

    localparam int W  = MAX_WIDTH;
    localparam int LW = $clog2(W + 1);
    localparam int L  = $clog2(W);
    localparam int P  = 1 << L;
    localparam int NN = 2 * P - 1;
    localparam int D  = 4 + L;

    // length register
    logic [LEN_W-1:0] len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LEN_RESET;
        end else if (cfg_wr_en) begin
            len_reg <= cfg_wr_data;
        end
    end

    // pipeline control: every stage advances when the result register can move
    logic         adv;
    logic [D-1:0] valid_reg;

    assign adv     = !valid_reg[D-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = valid_reg[D-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[D-2:0], s_valid};
        end
    end

    // effective length, clamped to 1..W, and its mask
    logic [LW-1:0] n_eff;
    logic [W-1:0]  mask_eff;

    always_comb begin
        if (len_reg == '0) begin
            n_eff = LW'(1);
        end else if (len_reg > LEN_W'(W)) begin
            n_eff = LW'(W);
        end else begin
            n_eff = LW'(len_reg);
        end
        mask_eff = (n_eff == LW'(W)) ? '1 : ((W'(1) << n_eff) - W'(1));
    end

    // stage 1: masked word
    logic [W-1:0]  w1_reg;
    logic [W-1:0]  mask1_reg;
    logic [LW-1:0] n1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            w1_reg    <= s_word[W-1:0] & mask_eff;
            mask1_reg <= mask_eff;
            n1_reg    <= n_eff;
        end
    end

    // stage 2: mirror image within the string length
    logic [W-1:0]  flip_w;
    logic [W-1:0]  rev_next;
    logic [W-1:0]  w2_reg;
    logic [W-1:0]  rev2_reg;
    logic [W-1:0]  mask2_reg;
    logic [LW-1:0] n2_reg;

    for (genvar i = 0; i < W; i++) begin : g_flip
        assign flip_w[i] = w1_reg[W-1-i];
    end

    assign rev_next = flip_w >> (LW'(W) - n1_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            w2_reg    <= w1_reg;
            rev2_reg  <= rev_next;
            mask2_reg <= mask1_reg;
            n2_reg    <= n1_reg;
        end
    end

    // stage 3: doubled strings, so every rotation is a fixed window
    logic [2*W-1:0] dw_next;
    logic [2*W-1:0] dr_next;
    logic [2*W-1:0] dw3_reg;
    logic [2*W-1:0] dr3_reg;
    logic [W-1:0]   mask3_reg;
    logic [LW-1:0]  n3_reg;

    assign dw_next = {{W{1'b0}}, w2_reg} | ({{W{1'b0}}, w2_reg} << n2_reg);
    assign dr_next = {{W{1'b0}}, rev2_reg} | ({{W{1'b0}}, rev2_reg} << n2_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            dw3_reg   <= dw_next;
            dr3_reg   <= dr_next;
            mask3_reg <= mask2_reg;
            n3_reg    <= n2_reg;
        end
    end

    // stage 4 onward: min tree stored as a heap, leaves at P-1 and up
    logic [W-1:0] node_reg [NN];

    for (genvar j = 0; j < P; j++) begin : g_leaf
        if (j < W) begin : g_real
            logic [W-1:0] rot_a;
            logic [W-1:0] rot_b;
            // windows past the length fall back to the unrotated string
            assign rot_a = ((LW'(j) < n3_reg) ? dw3_reg[j +: W] : dw3_reg[0 +: W])
                           & mask3_reg;
            assign rot_b = ((LW'(j) < n3_reg) ? dr3_reg[j +: W] : dr3_reg[0 +: W])
                           & mask3_reg;
            always_ff @(posedge aclk) begin
                if (adv) begin
                    node_reg[P-1+j] <= (rot_b < rot_a) ? rot_b : rot_a;
                end
            end
        end else begin : g_pad
            // padding leaves never win
            always_ff @(posedge aclk) begin
                if (adv) begin
                    node_reg[P-1+j] <= '1;
                end
            end
        end
    end

    // inner nodes: one registered compare per tree level
    for (genvar k = 0; k < P - 1; k++) begin : g_node
        always_ff @(posedge aclk) begin
            if (adv) begin
                node_reg[k] <= (node_reg[2*k+2] < node_reg[2*k+1]) ?
                               node_reg[2*k+2] : node_reg[2*k+1];
            end
        end
    end

    // result beat
    assign m_canonical_word = WORD_W'(node_reg[0]);

endmodule

>>> bench/tb_top.sv
// testbench for bracelet_canonical_form: queued stimulus with a self-checking predictor
`timescale 1ns / 1ps

module tb_top;
    import bcf_pkg::*;

    localparam int MAXW      = MAX_WIDTH_DEF;
    localparam int LATENCY   = 4 + $clog2(MAXW);
    localparam int LONG_HOLD = 300;
    localparam int LIMIT     = 400000;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0]    cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [WORD_W-1:0]   s_word      = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [WORD_W-1:0]   m_canonical_word;

    // stimulus and expectation stores
    logic [WORD_W-1:0]   pending_words[$];
    logic [WORD_W-1:0]   expected_canon[$];
    logic [LEN_W-1:0]    len_shadow = LEN_RESET;

    bit                  run_go    = 1'b0;
    bit                  idle_on   = 1'b1;
    bit                  hold_req  = 1'b0;
    bit                  beat_sent = 1'b0;
    int                  send_gap  = 0;
    int                  recv_wait = 0;
    int                  fail_cnt  = 0;
    int                  cycles    = 0;

    bracelet_canonical_form DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_word           (s_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_canonical_word (m_canonical_word)
    );

    always #5 aclk = ~aclk;

    // smallest rotation of the masked string or of its mirror image
    function automatic logic [WORD_W-1:0] bracelet_min(input logic [WORD_W-1:0] w,
                                                       input logic [LEN_W-1:0] len_code);
        int                n;
        int                i;
        int                sh;
        logic [WORD_W-1:0] msk;
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] mir;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] best;
        n = int'(len_code);
        if (n < 1) n = 1;
        if (n > MAXW) n = MAXW;
        msk = (n >= WORD_W) ? '1 : ((64'd1 << n) - 64'd1);
        v = w & msk;
        mir = '0;
        for (i = 0; i < n; i++) begin
            if (v[i]) mir[n-1-i] = 1'b1;
        end
        best = v;
        for (sh = 0; sh < n; sh++) begin
            a = (sh == 0) ? v : (((v << sh) | (v >> (n - sh))) & msk);
            b = (sh == 0) ? mir : (((mir << sh) | (mir >> (n - sh))) & msk);
            if (a < best) best = a;
            if (b < best) best = b;
        end
        return best;
    endfunction

    // random word: dense, sparse, fully random or a short repeating pattern
    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] v;
        logic [7:0]        pat;
        int                per;
        int                i;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 3))
            1: begin
                v = v & {$urandom(), $urandom()} & {$urandom(), $urandom()};
            end
            2: begin
                v = v | {$urandom(), $urandom()} | {$urandom(), $urandom()};
            end
            3: begin
                per = $urandom_range(1, 8);
                pat = 8'($urandom());
                for (i = 0; i < WORD_W; i++) v[i] = pat[i % per];
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    // input side: record accepted beats and their expected result
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            expected_canon = {expected_canon, bracelet_min(s_word, len_shadow)};
            beat_sent = 1'b1;
            send_gap = idle_on ? $urandom_range(0, 5) : 0;
        end
    end

    // driver: present the next pending word after the drawn gap
    always @(negedge aclk) begin
        if (run_go && (!s_valid || beat_sent)) begin
            beat_sent = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                s_word  <= pending_words.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (expected_canon.size() == 0) begin
                $error("canonical_word: unexpected beat, got %h", m_canonical_word);
                fail_cnt++;
            end else begin
                if (m_canonical_word !== expected_canon[0]) begin
                    $error("canonical_word mismatch: expected %h, actual %h",
                           expected_canon[0], m_canonical_word);
                    fail_cnt++;
                end
                void'(expected_canon.pop_front());
            end
            recv_wait = idle_on ? $urandom_range(0, 5) : 0;
        end
    end

    // receiver ready, with per-beat stalls and the occasional long hold
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            recv_wait = LONG_HOLD;
        end
        if (recv_wait > 0) begin
            recv_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // wait until every queued word is sent and every result has come back
    task automatic drain();
        while (pending_words.size() > 0 || s_valid || expected_canon.size() > 0)
            @(negedge aclk);
    endtask

    // write the length register once the block is idle
    task automatic set_length(input logic [LEN_W-1:0] len_code);
        drain();
        repeat (LATENCY) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len_code;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= LEN_W'($urandom());
        len_shadow = len_code;
    endtask

    // append one word to the pending stimulus
    task automatic queue_word(input logic [WORD_W-1:0] w);
        pending_words = {pending_words, w};
    endtask

    task automatic push_random(input int count);
        int k;
        for (k = 0; k < count; k++) queue_word(pick_word());
    endtask

    // phase sequence
    initial begin
        logic [LEN_W-1:0] sweep[14];
        int               p;
        sweep = '{7'd2, 7'd3, 7'd4, 7'd5, 7'd7, 7'd8, 7'd13, 7'd16,
                  7'd31, 7'd32, 7'd33, 7'd48, 7'd63, 7'd64};

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        run_go = 1'b1;

        // full length after reset: extremes, alternation, mirror-sensitive words
        queue_word(64'h0000_0000_0000_0000);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(64'h0000_0000_0000_0001);
        queue_word(64'h8000_0000_0000_0000);
        queue_word(64'h8000_0000_0000_0001);
        queue_word(64'hAAAA_AAAA_AAAA_AAAA);
        queue_word(64'h5555_5555_5555_5555);
        queue_word(64'h0000_0000_0000_000B);
        queue_word(64'hFFFF_FFFF_FFFF_FFFE);
        queue_word(64'h0123_4567_89AB_CDEF);
        queue_word(64'hFEDC_BA98_7654_3210);
        push_random(100);

        // single-bit string, bits above ignored
        set_length(7'd1);
        queue_word(64'h0000_0000_0000_0000);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(64'hFFFF_FFFF_FFFF_FFFE);
        push_random(60);

        // zero length behaves as one
        set_length(7'd0);
        queue_word(64'h0000_0000_0000_0001);
        queue_word(64'hFFFF_FFFF_FFFF_FFFE);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF);
        push_random(60);

        // lengths above the maximum saturate
        set_length(7'd127);
        queue_word(64'h0000_0000_0000_000B);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF);
        push_random(100);

        set_length(7'd65);
        push_random(80);

        // length sweep; every third phase and the last with no idling, the last with a long receiver hold
        for (p = 0; p < 14; p++) begin
            set_length(sweep[p]);
            idle_on = (p % 3 != 2);
            if (p == 13) begin
                idle_on = 1'b0;
                @(posedge aclk);
                hold_req = 1'b1;
            end
            push_random(100);
        end

        // a few arbitrary register values
        idle_on = 1'b1;
        for (p = 0; p < 4; p++) begin
            set_length(LEN_W'($urandom_range(0, 127)));
            push_random(60);
        end

        drain();
        repeat (LATENCY + 5) @(negedge aclk);
        if (expected_canon.size() != 0) begin
            $error("canonical_word: %0d results never arrived", expected_canon.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/bcf_pkg.sv
rtl/bracelet_canonical_form.sv
bench/tb_top.sv
